// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the barrier counter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define QBC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("%m: same-cycle implication failed");

// next-cycle implication
`define QBC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("%m: next-cycle implication failed");

`endif

// ----- rtl/core/qbc_pkg.sv -----
// ----------------------------------------------------------------------------
// qbc_pkg
// Types, constants and register codes of the quad tree barrier counter.
// ----------------------------------------------------------------------------
package qbc_pkg;

	localparam int DEF_COORD_BITS = 4;
	localparam int DEF_MAX_LEVELS = 5;
	localparam int DEF_MAX_PROCS  = 8;

	localparam int MESH_W  = 5;
	localparam int LVL_W   = 3;
	localparam int PPC_W   = 4;
	localparam int CFG_W   = 5;
	localparam int CIDX_W  = 2;
	localparam int UCNT_W  = 2;
	localparam int ARITY_W = 3;

	localparam logic [MESH_W-1:0] RST_MESH_WIDTH  = 5'd16;
	localparam logic [MESH_W-1:0] RST_MESH_HEIGHT = 5'd16;
	localparam logic [LVL_W-1:0]  RST_TREE_LEVELS = 3'd5;
	localparam logic [PPC_W-1:0]  RST_PROCS       = 4'd4;

	typedef enum logic [CIDX_W-1:0] {
		CFG_MESH_WIDTH,
		CFG_MESH_HEIGHT,
		CFG_TREE_LEVELS,
		CFG_PROCS
	} qbc_cfg_idx_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LEAF,
		ST_UPPER
	} qbc_state_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic leaf_step;
		logic up_step;
		logic finish;
	} qbc_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic bad;
		logic leaf_fill;
		logic up_fill;
		logic at_root;
	} qbc_stat_t;

endpackage

// ----- rtl/core/quadtree_barrier_counter.sv -----
// ----------------------------------------------------------------------------
// quadtree_barrier_counter
// Sense-reversing quad tree barrier: counts cluster arrivals level by level.
// ----------------------------------------------------------------------------
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+---------------------------
//  arrival   | cluster_x, cluster_y                   | start high, busy low
//  result    | levels_completed, barrier_done,        | result_strobe, one cycle
//            | root_phase, bad_cluster                |
//  config    | cfg_index, cfg_wdata                   | cfg_we, no wait
//
//  After reset all 2^(2*COORD_BITS) leaf entries (256 by default) and the upper
//  node entries are cleared with busy high; config writes are taken meanwhile.
//  An arrival keeps busy high through the leaf update and one node
//  read-modify-write per upper level it climbs (0 to tree_levels-1).
//  The result strobe rises in the cycle after the last node update; the
//  receiver cannot stall, and each word is flagged for exactly one cycle.
// ----------------------------------------------------------------------------
module quadtree_barrier_counter #(
	parameter int COORD_BITS = qbc_pkg::DEF_COORD_BITS,
	parameter int MAX_LEVELS = qbc_pkg::DEF_MAX_LEVELS,
	parameter int MAX_PROCS  = qbc_pkg::DEF_MAX_PROCS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [COORD_BITS-1:0]       cluster_x,
	input  logic [COORD_BITS-1:0]       cluster_y,
	output logic                        result_strobe,
	output logic [qbc_pkg::LVL_W-1:0]   levels_completed,
	output logic                        barrier_done,
	output logic                        root_phase,
	output logic                        bad_cluster,
	input  logic                        cfg_we,
	input  logic [qbc_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [qbc_pkg::CFG_W-1:0]   cfg_wdata
);
	import qbc_pkg::*;

	qbc_cmd_t          cmd;
	qbc_stat_t         stat;
	logic [COORD_BITS:0] w_eff;
	logic [COORD_BITS:0] h_eff;
	logic [LVL_W-1:0]  nl_eff;
	logic [PPC_W-1:0]  ppc_eff;

	qbc_cfg #(
		.COORD_BITS (COORD_BITS),
		.MAX_LEVELS (MAX_LEVELS),
		.MAX_PROCS  (MAX_PROCS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.w_eff     (w_eff),
		.h_eff     (h_eff),
		.nl_eff    (nl_eff),
		.ppc_eff   (ppc_eff)
	);

	qbc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	qbc_datapath #(
		.COORD_BITS (COORD_BITS),
		.MAX_PROCS  (MAX_PROCS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cluster_x        (cluster_x),
		.cluster_y        (cluster_y),
		.w_eff            (w_eff),
		.h_eff            (h_eff),
		.nl_eff           (nl_eff),
		.ppc_eff          (ppc_eff),
		.result_strobe    (result_strobe),
		.levels_completed (levels_completed),
		.barrier_done     (barrier_done),
		.root_phase       (root_phase),
		.bad_cluster      (bad_cluster)
	);

endmodule

// ----- rtl/core/qbc_cfg.sv -----
// ----------------------------------------------------------------------------
// qbc_cfg
// Configuration registers and their clamped working values.
// ----------------------------------------------------------------------------
module qbc_cfg #(
	parameter int COORD_BITS = qbc_pkg::DEF_COORD_BITS,
	parameter int MAX_LEVELS = qbc_pkg::DEF_MAX_LEVELS,
	parameter int MAX_PROCS  = qbc_pkg::DEF_MAX_PROCS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [qbc_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [qbc_pkg::CFG_W-1:0]   cfg_wdata,
	output logic [COORD_BITS:0]         w_eff,
	output logic [COORD_BITS:0]         h_eff,
	output logic [qbc_pkg::LVL_W-1:0]   nl_eff,
	output logic [qbc_pkg::PPC_W-1:0]   ppc_eff
);
	import qbc_pkg::*;

	localparam int GRID       = 1 << COORD_BITS;
	localparam int TOP_LEVELS = (MAX_LEVELS < COORD_BITS + 1) ? MAX_LEVELS : COORD_BITS + 1;

	logic [MESH_W-1:0] mesh_width_q;
	logic [MESH_W-1:0] mesh_height_q;
	logic [LVL_W-1:0]  tree_levels_q;
	logic [PPC_W-1:0]  procs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mesh_width_q  <= RST_MESH_WIDTH;
			mesh_height_q <= RST_MESH_HEIGHT;
			tree_levels_q <= RST_TREE_LEVELS;
			procs_q       <= RST_PROCS;
		end else if (cfg_we) begin
			unique case (qbc_cfg_idx_t'(cfg_index))
				CFG_MESH_WIDTH:  mesh_width_q  <= cfg_wdata[MESH_W-1:0];
				CFG_MESH_HEIGHT: mesh_height_q <= cfg_wdata[MESH_W-1:0];
				CFG_TREE_LEVELS: tree_levels_q <= cfg_wdata[LVL_W-1:0];
				CFG_PROCS:       procs_q       <= cfg_wdata[PPC_W-1:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		if (mesh_width_q == '0)
			w_eff = (COORD_BITS+1)'(1);
		else if (mesh_width_q > MESH_W'(GRID))
			w_eff = (COORD_BITS+1)'(GRID);
		else
			w_eff = (COORD_BITS+1)'(mesh_width_q);

		if (mesh_height_q == '0)
			h_eff = (COORD_BITS+1)'(1);
		else if (mesh_height_q > MESH_W'(GRID))
			h_eff = (COORD_BITS+1)'(GRID);
		else
			h_eff = (COORD_BITS+1)'(mesh_height_q);

		if (tree_levels_q == '0)
			nl_eff = LVL_W'(1);
		else if (tree_levels_q > LVL_W'(TOP_LEVELS))
			nl_eff = LVL_W'(TOP_LEVELS);
		else
			nl_eff = tree_levels_q;

		if (procs_q == '0)
			ppc_eff = PPC_W'(1);
		else if (procs_q > PPC_W'(MAX_PROCS))
			ppc_eff = PPC_W'(MAX_PROCS);
		else
			ppc_eff = procs_q;
	end

endmodule

// ----- rtl/core/qbc_ctrl.sv -----
// ----------------------------------------------------------------------------
// qbc_ctrl
// Sequencer: clearing pass, leaf update, then one tree level per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qbc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output qbc_pkg::qbc_cmd_t  cmd,
	input  qbc_pkg::qbc_stat_t stat
);
	import qbc_pkg::*;

	qbc_state_t state_q;
	qbc_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last)
					state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = ST_LEAF;
				end
			end
			ST_LEAF: begin
				cmd.leaf_step = 1'b1;
				if (!stat.bad && stat.leaf_fill && !stat.at_root) begin
					state_nxt = ST_UPPER;
				end else begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			ST_UPPER: begin
				cmd.up_step = 1'b1;
				if (!(stat.up_fill && !stat.at_root)) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	`QBC_ASSERT_NXT(a_start_to_leaf, clk, arst_n, start && !busy, state_q == ST_LEAF)
	`QBC_ASSERT_IMP(a_leaf_from_idle, clk, arst_n, state_q == ST_LEAF, $past(state_q) == ST_IDLE)

endmodule

// ----- rtl/core/qbc_datapath.sv -----
// ----------------------------------------------------------------------------
// qbc_datapath
// Node counter memories, per-level update logic and result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qbc_datapath #(
	parameter int COORD_BITS = qbc_pkg::DEF_COORD_BITS,
	parameter int MAX_PROCS  = qbc_pkg::DEF_MAX_PROCS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  qbc_pkg::qbc_cmd_t           cmd,
	output qbc_pkg::qbc_stat_t          stat,
	input  logic [COORD_BITS-1:0]       cluster_x,
	input  logic [COORD_BITS-1:0]       cluster_y,
	input  logic [COORD_BITS:0]         w_eff,
	input  logic [COORD_BITS:0]         h_eff,
	input  logic [qbc_pkg::LVL_W-1:0]   nl_eff,
	input  logic [qbc_pkg::PPC_W-1:0]   ppc_eff,
	output logic                        result_strobe,
	output logic [qbc_pkg::LVL_W-1:0]   levels_completed,
	output logic                        barrier_done,
	output logic                        root_phase,
	output logic                        bad_cluster
);
	import qbc_pkg::*;

	localparam int CB      = COORD_BITS;
	localparam int LA_W    = 2 * CB;
	localparam int LEAF_N  = 1 << LA_W;
	localparam int UPPER_N = (LEAF_N - 1) / 3;
	localparam int UA_W    = (UPPER_N > 1) ? $clog2(UPPER_N) : 1;
	localparam int LCW     = (MAX_PROCS > 2) ? $clog2(MAX_PROCS) : 1;
	localparam int CMP_W   = PPC_W + 1;

	// position of the level-l node covering (x, y), l >= 1
	function automatic logic [UA_W-1:0] slot_of(input logic [LVL_W-1:0] l,
			input logic [CB-1:0] x, input logic [CB-1:0] y);
		int unsigned off;
		int unsigned pos;
		off = 0;
		for (int k = 1; k < CB; k++) begin
			if (k < int'(l))
				off += 1 << (2 * (CB - k));
		end
		pos = off + (((int'(x) >> l) << (CB - int'(l))) | (int'(y) >> l));
		if (l == '0 || pos >= UPPER_N)
			pos = 0;
		return UA_W'(pos);
	endfunction

	// children of the level-l node that lie inside the mesh
	function automatic logic [ARITY_W-1:0] arity_of(input logic [LVL_W-1:0] l,
			input logic [CB-1:0] x, input logic [CB-1:0] y,
			input logic [CB:0] w, input logic [CB:0] h);
		logic [CB:0]        bx;
		logic [CB:0]        by;
		logic [CB:0]        half;
		logic [CB:0]        cx;
		logic [CB:0]        cy;
		logic [ARITY_W-1:0] a;
		bx   = ({1'b0, x} >> l) << l;
		by   = ({1'b0, y} >> l) << l;
		half = (CB+1)'(1) << (l - LVL_W'(1));
		a    = '0;
		for (int i = 0; i < 4; i++) begin
			cx = bx + (((i & 1) != 0) ? half : '0);
			cy = by + (((i & 2) != 0) ? half : '0);
			if (cx < w && cy < h)
				a = a + ARITY_W'(1);
		end
		if (a == '0)
			a = ARITY_W'(1);
		return a;
	endfunction

	logic [LCW:0]    leaf_mem [LEAF_N];
	logic [UCNT_W:0] upper_mem [UPPER_N];
	logic [LCW:0]    leaf_rd_q;
	logic [UCNT_W:0] upper_rd_q;

	logic [LA_W-1:0]     clr_q;
	logic [CB-1:0]       x_q;
	logic [CB-1:0]       y_q;
	logic                bad_q;
	logic [LVL_W-1:0]    lvl_q;
	logic [LVL_W-1:0]    done_q;
	logic                sense_q;

	logic [LVL_W-1:0]    root;
	logic                bad_in;
	logic [LA_W-1:0]     leaf_raddr;
	logic [UA_W-1:0]     upper_raddr;
	logic [UA_W-1:0]     upper_waddr;
	logic [CMP_W-1:0]    leaf_c;
	logic [ARITY_W-1:0]  up_c;
	logic [ARITY_W-1:0]  arity;
	logic                leaf_fill;
	logic                up_fill;
	logic                at_root;
	logic [LCW:0]        leaf_wdata;
	logic [UCNT_W:0]     upper_wdata;
	logic [LVL_W-1:0]    done_nxt;
	logic                sense_nxt;
	logic                base_sense;

	assign root    = nl_eff - LVL_W'(1);
	assign at_root = (lvl_q == root);

	assign bad_in = ({1'b0, cluster_x} >= w_eff) || ({1'b0, cluster_y} >= h_eff) ||
		((cluster_x >> root) != '0) || ((cluster_y >> root) != '0);

	assign leaf_raddr  = bad_in ? '0 : {cluster_x, cluster_y};
	assign upper_raddr = (cmd.leaf_step || cmd.up_step) ?
		slot_of(lvl_q + LVL_W'(1), x_q, y_q) : slot_of(root, '0, '0);
	assign upper_waddr = slot_of(lvl_q, x_q, y_q);

	assign leaf_c    = CMP_W'(leaf_rd_q[LCW-1:0]) + CMP_W'(1);
	assign leaf_fill = (leaf_c >= CMP_W'(ppc_eff));
	assign leaf_wdata = leaf_fill ? {~leaf_rd_q[LCW], {LCW{1'b0}}} :
		{leaf_rd_q[LCW], leaf_c[LCW-1:0]};

	assign arity       = arity_of(lvl_q, x_q, y_q, w_eff, h_eff);
	assign up_c        = ARITY_W'(upper_rd_q[UCNT_W-1:0]) + ARITY_W'(1);
	assign up_fill     = (up_c >= arity);
	assign upper_wdata = up_fill ? {~upper_rd_q[UCNT_W], {UCNT_W{1'b0}}} :
		{upper_rd_q[UCNT_W], up_c[UCNT_W-1:0]};

	assign base_sense = at_root ? leaf_rd_q[LCW] : upper_rd_q[UCNT_W];

	always_comb begin
		done_nxt  = done_q;
		sense_nxt = sense_q;
		if (cmd.leaf_step) begin
			done_nxt  = (!bad_q && leaf_fill) ? LVL_W'(1) : '0;
			sense_nxt = base_sense ^ (!bad_q && leaf_fill && at_root);
		end else if (cmd.up_step) begin
			done_nxt  = done_q + LVL_W'(up_fill);
			sense_nxt = sense_q ^ (up_fill && at_root);
		end
	end

	assign stat.clr_last  = (clr_q == '1);
	assign stat.bad       = bad_q;
	assign stat.leaf_fill = leaf_fill;
	assign stat.up_fill   = up_fill;
	assign stat.at_root   = at_root;

	// memories: one write and one registered read each per cycle
	always_ff @(posedge clk) begin
		if (cmd.clr)
			leaf_mem[clr_q] <= '0;
		else if (cmd.leaf_step && !bad_q)
			leaf_mem[{x_q, y_q}] <= leaf_wdata;
		leaf_rd_q <= leaf_mem[leaf_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			if (clr_q < LA_W'(UPPER_N))
				upper_mem[clr_q[UA_W-1:0]] <= '0;
		end else if (cmd.up_step) begin
			upper_mem[upper_waddr] <= upper_wdata;
		end
		upper_rd_q <= upper_mem[upper_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q         <= '0;
			lvl_q         <= '0;
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= cmd.finish;
			if (cmd.clr)
				clr_q <= clr_q + LA_W'(1);
			if (cmd.load)
				lvl_q <= '0;
			else if (cmd.leaf_step || cmd.up_step)
				lvl_q <= lvl_q + LVL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q   <= cluster_x;
			y_q   <= cluster_y;
			bad_q <= bad_in;
		end
		done_q  <= done_nxt;
		sense_q <= sense_nxt;
		if (cmd.finish) begin
			levels_completed <= done_nxt;
			barrier_done     <= (done_nxt == nl_eff);
			root_phase       <= sense_nxt;
			bad_cluster      <= bad_q;
		end
	end

	`QBC_ASSERT_IMP(a_bad_no_climb, clk, arst_n, result_strobe && bad_cluster, levels_completed == '0 && !barrier_done)
	`QBC_ASSERT_IMP(a_up_level_range, clk, arst_n, cmd.up_step, lvl_q != '0 && lvl_q <= root)

endmodule
